// ----- rtl/core/alcd_pkg.sv -----
// Package for the ASCII line command decoder.
// Keyword table, character codes, scan types and the result struct.
// No dependencies.
`default_nettype none

package alcd_pkg;

  localparam int unsigned LINE_BYTES_DEF = 32;
  localparam int unsigned KW_NUM         = 6;
  localparam int unsigned TARGET_W       = 3;
  localparam int unsigned VALUE_W        = 32;

  localparam logic [7:0] ASCII_NUL   = 8'h00;
  localparam logic [7:0] ASCII_TAB   = 8'h09;
  localparam logic [7:0] ASCII_LF    = 8'h0A;
  localparam logic [7:0] ASCII_CR    = 8'h0D;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_NINE  = 8'h39;

  // keyword text, padded with zero bytes to eight characters
  localparam logic [7:0] KW_TEXT [KW_NUM][8] = '{
    '{"I", "G", "N", " ", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "O", "O", "R", " ", 8'h00, 8'h00, 8'h00},
    '{"L", "O", "C", "K", " ", 8'h00, 8'h00, 8'h00},
    '{"B", "L", "I", "N", "K", " ", 8'h00, 8'h00},
    '{"W", "I", "P", " ", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "P", "D", " ", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [KW_NUM] = '{3'd4, 3'd5, 3'd5, 3'd6, 3'd4, 3'd4};

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_RUN,
    SC_DONE
  } scan_state_e;

  typedef enum logic [1:0] {
    PH_KW,
    PH_SKIP,
    PH_DIG
  } scan_phase_e;

  typedef struct packed {
    logic [TARGET_W-1:0] target;
    logic [VALUE_W-1:0]  value;
  } alcd_result_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ASCII_SPACE) || ((c >= ASCII_TAB) && (c <= ASCII_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
  endfunction

endpackage : alcd_pkg

`default_nettype wire

// ----- rtl/core/alcd_line_ram.sv -----
// Line store: one write port, one read port, registered read data.
// Depends on nothing but its parameter.
`default_nettype none

module alcd_line_ram #(
  parameter int unsigned LINE_BYTES = 32,
  localparam int unsigned AW = $clog2(LINE_BYTES)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [LINE_BYTES];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : alcd_line_ram

`default_nettype wire

// ----- rtl/core/alcd_scan.sv -----
// Line scanner: walks the line store one byte per cycle, matches keywords
// and converts the trailing decimal number. Uses alcd_pkg.
`default_nettype none

module alcd_scan
  import alcd_pkg::*;
#(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF,
  localparam int unsigned AW = $clog2(LINE_BYTES)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [AW-1:0] len_i,
  output logic               rd_en_o,
  output logic      [AW-1:0] rd_addr_o,
  input  wire logic [7:0]    rd_data_i,
  output logic               busy_o,
  output logic               res_valid_o,
  input  wire logic          res_ready_i,
  output alcd_result_t       res_o
);

  scan_state_e         state_q, state_d;
  scan_phase_e         phase_q, phase_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [AW-1:0]       len_q, len_d;
  logic [KW_NUM-1:0]   alive_q, alive_d;
  logic [TARGET_W-1:0] target_q, target_d;
  logic [VALUE_W-1:0]  acc_q, acc_d;
  logic                neg_q, neg_d;

  logic                end_txt;
  logic                kw_hit;
  logic [TARGET_W-1:0] kw_idx;
  logic [KW_NUM-1:0]   alive_nx;
  logic [3:0]          dig;
  logic                finish_res, finish_none;

  assign end_txt = (pos_q == len_q) || (rd_data_i == ASCII_NUL);
  assign dig     = rd_data_i[3:0];

  always_comb begin
    kw_hit   = 1'b0;
    kw_idx   = '0;
    alive_nx = '0;
    for (int k = 0; k < KW_NUM; k++) begin
      alive_nx[k] = alive_q[k] && (pos_q < AW'(KW_LEN[k]))
                    && (rd_data_i == KW_TEXT[k][pos_q[2:0]]);
      if (alive_nx[k] && (pos_q == AW'(KW_LEN[k] - 3'd1)) && !kw_hit) begin
        kw_hit = 1'b1;
        kw_idx = TARGET_W'(k);
      end
    end
  end

  // byte classification and end conditions while running
  always_comb begin
    finish_res  = 1'b0;
    finish_none = 1'b0;
    if (end_txt) begin
      finish_res  = (phase_q != PH_KW);
      finish_none = (phase_q == PH_KW);
    end else begin
      unique case (phase_q)
        PH_KW: begin
          finish_none = !kw_hit && (alive_nx == '0);
        end
        PH_SKIP: begin
          finish_res = !is_blank(rd_data_i) && !is_digit(rd_data_i)
                       && (rd_data_i != ASCII_PLUS) && (rd_data_i != ASCII_MINUS);
        end
        PH_DIG: begin
          finish_res = !is_digit(rd_data_i);
        end
        default: begin
          finish_none = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          state_d = SC_RUN;
        end
      end
      SC_RUN: begin
        if (finish_res) begin
          state_d = SC_DONE;
        end else if (finish_none) begin
          state_d = SC_IDLE;
        end
      end
      SC_DONE: begin
        if (res_ready_i) begin
          state_d = SC_IDLE;
        end
      end
      default: state_d = SC_IDLE;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    len_d    = len_q;
    alive_d  = alive_q;
    target_d = target_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    if (state_q == SC_IDLE) begin
      if (start_i) begin
        phase_d = PH_KW;
        pos_d   = '0;
        len_d   = len_i;
        alive_d = '1;
        acc_d   = '0;
        neg_d   = 1'b0;
      end
    end else if (state_q == SC_RUN && !end_txt) begin
      pos_d = pos_q + AW'(1);
      unique case (phase_q)
        PH_KW: begin
          alive_d = alive_nx;
          if (kw_hit) begin
            phase_d  = PH_SKIP;
            target_d = kw_idx;
          end
        end
        PH_SKIP: begin
          if ((rd_data_i == ASCII_PLUS) || (rd_data_i == ASCII_MINUS)) begin
            neg_d   = (rd_data_i == ASCII_MINUS);
            phase_d = PH_DIG;
          end else if (is_digit(rd_data_i)) begin
            acc_d   = VALUE_W'(dig);
            phase_d = PH_DIG;
          end
        end
        PH_DIG: begin
          if (is_digit(rd_data_i)) begin
            acc_d = (acc_q << 3) + (acc_q << 1) + VALUE_W'(dig);
          end
        end
        default: phase_d = PH_KW;
      endcase
    end
  end

  always_comb begin
    rd_en_o     = 1'b0;
    rd_addr_o   = '0;
    busy_o      = (state_q != SC_IDLE);
    res_valid_o = (state_q == SC_DONE);
    unique case (state_q)
      SC_IDLE: begin
        rd_en_o = start_i;
      end
      SC_RUN: begin
        rd_en_o   = 1'b1;
        rd_addr_o = pos_q + AW'(1);
      end
      SC_DONE: begin
        rd_en_o = 1'b0;
      end
      default: rd_en_o = 1'b0;
    endcase
  end

  assign res_o.target = target_q;
  assign res_o.value  = neg_q ? (VALUE_W'(0) - acc_q) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      phase_q <= PH_KW;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    len_q    <= len_d;
    alive_q  <= alive_d;
    target_q <= target_d;
    acc_q    <= acc_d;
    neg_q    <= neg_d;
  end

endmodule : alcd_scan

`default_nettype wire

// ----- rtl/core/ascii_line_command_decoder.sv -----
// Top level of the ASCII line command decoder.
// Uses alcd_pkg, alcd_line_ram and alcd_scan.
//
//   channel  direction  handshake                payload
//   rx       in         rx_valid_i / rx_ready_o  rx_byte_i
//   res      out        res_valid_o / res_ready_i target_o, value_o
//
// An ordinary byte is written into the line RAM unless LINE_BYTES - 1 bytes are already stored.
// A CR or LF starts a scan through the line RAM, one byte per cycle.
// rx stalls while the scan runs or a scan result waits for the output slot.
// The output register lets bytes be taken while a result waits on res.
// Reset clears the fill count, the scanner and the output valid.
`default_nettype none

module ascii_line_command_decoder
  import alcd_pkg::*;
#(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rx_valid_i,
  output logic                     rx_ready_o,
  input  wire logic [7:0]          rx_byte_i,
  output logic                     res_valid_o,
  input  wire logic                res_ready_i,
  output logic      [TARGET_W-1:0] target_o,
  output logic      [VALUE_W-1:0]  value_o
);

  localparam int unsigned AW = $clog2(LINE_BYTES);
  localparam logic [AW-1:0] FILL_MAX = AW'(LINE_BYTES - 1);

  logic [AW-1:0] fill_q, fill_d;
  logic          rx_acc, eol, wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          scan_busy, scan_vld, scan_rdy;
  alcd_result_t  scan_res;
  logic          out_vld_q, out_vld_d;
  alcd_result_t  out_q;

  assign rx_ready_o = !scan_busy;
  assign rx_acc     = rx_valid_i && rx_ready_o;
  assign eol        = (rx_byte_i == ASCII_LF) || (rx_byte_i == ASCII_CR);
  assign wr_en      = rx_acc && !eol && (fill_q != FILL_MAX);

  always_comb begin
    fill_d = fill_q;
    if (rx_acc && eol) begin
      fill_d = '0;
    end else if (wr_en) begin
      fill_d = fill_q + AW'(1);
    end
  end

  alcd_line_ram #(
    .LINE_BYTES (LINE_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (fill_q),
    .wdata_i (rx_byte_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  alcd_scan #(
    .LINE_BYTES (LINE_BYTES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (rx_acc && eol),
    .len_i       (fill_q),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .busy_o      (scan_busy),
    .res_valid_o (scan_vld),
    .res_ready_i (scan_rdy),
    .res_o       (scan_res)
  );

  assign scan_rdy = !out_vld_q || res_ready_i;

  always_comb begin
    out_vld_d = out_vld_q;
    if (scan_vld && scan_rdy) begin
      out_vld_d = 1'b1;
    end else if (res_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_vld && scan_rdy) begin
      out_q <= scan_res;
    end
  end

  assign res_valid_o = out_vld_q;
  assign target_o    = out_q.target;
  assign value_o     = out_q.value;

  a_eol_stalls_rx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_acc && eol |=> !rx_ready_o && (fill_q == '0))
    else $error("line end did not start a scan");

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_MAX)
    else $error("fill count beyond line length");

  a_target_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (target_o < TARGET_W'(KW_NUM)))
    else $error("target code out of range");

  a_no_write_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_busy |-> !wr_en)
    else $error("line RAM written during scan");

endmodule : ascii_line_command_decoder

`default_nettype wire

// ----- tb/tb_ascii_line_command_decoder.sv -----
// Testbench for ascii_line_command_decoder: drives serial bytes, predicts the
// decoded keyword commands and checks every result transaction in order.
// Depends on alcd_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb_ascii_line_command_decoder;
  import alcd_pkg::*;

  localparam int unsigned LINE_MAX     = 32;
  localparam int unsigned TOTAL_BYTES  = 900;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 40;

  typedef enum logic [TARGET_W-1:0] {
    TGT_IGNITION,
    TGT_DOOR,
    TGT_LOCK,
    TGT_BLINKER,
    TGT_WIPERS,
    TGT_SPEED
  } target_e;

  typedef struct {
    logic [7:0] data;
    bit         drain;
  } rx_item_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                rx_valid    = 1'b0;
  logic [7:0]          rx_byte     = ASCII_NUL;
  logic                res_ready   = 1'b0;
  logic                rx_ready_o;
  logic                res_valid_o;
  logic [TARGET_W-1:0] target_o;
  logic [VALUE_W-1:0]  value_o;

  string kw_text [KW_NUM] = '{"IGN ", "DOOR ", "LOCK ", "BLINK ", "WIP ", "SPD "};

  rx_item_t     rx_pending_q[$];
  alcd_result_t cmd_expect_q[$];
  logic [7:0]   line_text [LINE_MAX];
  int unsigned  line_fill     = 0;
  int unsigned  bytes_queued  = 0;
  int unsigned  bytes_taken   = 0;
  int unsigned  mismatch_cnt  = 0;
  int unsigned  cycle_cnt     = 0;
  bit           drain_next    = 1'b0;
  logic         calm;

  assign calm = (bytes_taken >= 300) && (bytes_taken < 480);

  ascii_line_command_decoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte),
    .res_valid_o(res_valid_o),
    .res_ready_i(res_ready),
    .target_o   (target_o),
    .value_o    (value_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // line buffer update; a CR/LF decodes the stored text
  task automatic predict_line_byte(input logic [7:0] c);
    int unsigned  text_len;
    int unsigned  pos;
    bit           hit;
    bit           neg;
    logic [31:0]  acc;
    alcd_result_t cmd;
    if (c == ASCII_LF || c == ASCII_CR) begin
      text_len = 0;
      while (text_len < line_fill && line_text[text_len] != ASCII_NUL) text_len++;
      hit = 1'b0;
      for (int k = 0; k < KW_NUM; k++) begin
        if (!hit && text_len >= kw_text[k].len()) begin
          hit = 1'b1;
          for (int i = 0; i < kw_text[k].len(); i++) begin
            if (line_text[i] != kw_text[k][i]) hit = 1'b0;
          end
          if (hit) begin
            pos = kw_text[k].len();
            while (pos < text_len && (line_text[pos] == ASCII_SPACE ||
                   (line_text[pos] >= ASCII_TAB && line_text[pos] <= ASCII_CR))) pos++;
            neg = 1'b0;
            if (pos < text_len &&
                (line_text[pos] == ASCII_PLUS || line_text[pos] == ASCII_MINUS)) begin
              neg = (line_text[pos] == ASCII_MINUS);
              pos++;
            end
            acc = '0;
            while (pos < text_len && line_text[pos] >= ASCII_ZERO &&
                   line_text[pos] <= ASCII_NINE) begin
              acc = acc * 32'd10 + 32'(line_text[pos] - ASCII_ZERO);
              pos++;
            end
            cmd.target = target_e'(k);
            cmd.value  = neg ? -acc : acc;
            cmd_expect_q.push_back(cmd);
          end
        end
      end
      line_fill = 0;
    end else if (line_fill < LINE_MAX - 1) begin
      line_text[line_fill] = c;
      line_fill++;
    end
  endtask

  task automatic push_byte(input logic [7:0] c);
    rx_item_t item;
    item.data  = c;
    item.drain = drain_next;
    drain_next = 1'b0;
    rx_pending_q.push_back(item);
    bytes_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_line(input string s, input logic [7:0] term);
    push_text(s);
    push_byte(term);
  endtask

  function automatic logic [7:0] any_text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == ASCII_LF || c == ASCII_CR);
    return c;
  endfunction

  task automatic push_digits(input int unsigned n);
    for (int i = 0; i < n; i++) push_byte(ASCII_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic queue_random_line();
    int unsigned kind;
    int unsigned n;
    int unsigned bad;
    string       kw;
    logic [7:0]  blanks [4];
    blanks = '{ASCII_SPACE, ASCII_TAB, 8'h0B, 8'h0C};
    kind = $urandom_range(99);
    kw   = kw_text[$urandom_range(KW_NUM - 1)];
    if ($urandom_range(24) == 0) drain_next = 1'b1;
    if (kind < 65) begin
      push_text(kw);
      n = $urandom_range(3);
      repeat (n) push_byte(blanks[$urandom_range(3)]);
      case ($urandom_range(2))
        0: push_byte(ASCII_PLUS);
        1: push_byte(ASCII_MINUS);
        default: ;
      endcase
      push_digits(($urandom_range(9) == 0) ? $urandom_range(11, 14) : $urandom_range(10));
      if ($urandom_range(4) == 0) push_byte(any_text_byte());
    end else if (kind < 75) begin
      bad = $urandom_range(kw.len() - 1);
      for (int i = 0; i < kw.len(); i++) push_byte((i == bad) ? any_text_byte() : kw[i]);
      push_digits($urandom_range(1, 5));
    end else if (kind < 83) begin
      if ($urandom_range(1)) push_text(kw);
      n = $urandom_range(20, 40);
      repeat (n) push_byte($urandom_range(1) ? ASCII_ZERO + 8'($urandom_range(9))
                                             : any_text_byte());
    end else if (kind < 90) begin
      push_text(kw);
      push_digits($urandom_range(3));
      push_byte(ASCII_NUL);
      push_digits($urandom_range(1, 3));
    end else begin
      n = $urandom_range(12);
      repeat (n) push_byte(8'($urandom_range(255)));
    end
    push_byte($urandom_range(1) ? ASCII_CR : ASCII_LF);
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid <= 1'b0;
      rx_byte  <= ASCII_NUL;
    end else begin
      if (rx_valid && rx_ready_o) begin
        predict_line_byte(rx_byte);
        bytes_taken++;
      end
      if (!rx_valid || rx_ready_o) begin
        if (rx_pending_q.size() != 0 && (calm || $urandom_range(99) >= 17) &&
            !(rx_pending_q[0].drain && cmd_expect_q.size() != 0)) begin
          rx_valid <= 1'b1;
          rx_byte  <= rx_pending_q[0].data;
          rx_pending_q.delete(0);
        end else begin
          rx_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid_o && res_ready) begin
        if (cmd_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected command target=%0d value=%0d",
                                    target_o, $signed(value_o)));
        end else begin
          if (target_o !== cmd_expect_q[0].target)
            report_mismatch($sformatf("target %0d, expected %0d",
                                      target_o, cmd_expect_q[0].target));
          if (value_o !== cmd_expect_q[0].value)
            report_mismatch($sformatf("value %0d, expected %0d",
                                      $signed(value_o), $signed(cmd_expect_q[0].value)));
          cmd_expect_q.delete(0);
        end
      end
      res_ready <= calm || ($urandom_range(99) >= 17);
    end
  end

  initial begin
    push_line("IGN 0", ASCII_LF);
    push_line("DOOR -1", ASCII_CR);
    push_line("LOCK +2147483647", ASCII_LF);
    push_line("BLINK \t-2147483648", ASCII_CR);
    push_line("WIP 4294967297", ASCII_LF);
    push_line("SPD 12ab", ASCII_LF);
    push_line("SPD ", ASCII_CR);
    push_line("", ASCII_LF);
    push_line("ign 5", ASCII_CR);
    push_text("DOOR 1");
    push_byte(ASCII_NUL);
    push_line("9", ASCII_LF);
    push_byte(ASCII_NUL);
    push_line("IGN 3", ASCII_LF);
    push_line("IGN 7999999999999999999999999999999", ASCII_LF);
    push_text("WIP ");
    push_byte(8'hFF);
    push_byte(8'h80);
    push_line("5", ASCII_CR);
    push_line("BLINK -+5", ASCII_LF);
    drain_next = 1'b1;
    while (bytes_queued < TOTAL_BYTES) queue_random_line();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (rx_pending_q.size() != 0 || rx_valid) @(posedge clk_i);
    while (cmd_expect_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("status: fail");
    $finish;
  end

endmodule

// ----- ascii_line_command_decoder.f -----
rtl/core/alcd_pkg.sv
rtl/core/alcd_line_ram.sv
rtl/core/alcd_scan.sv
rtl/core/ascii_line_command_decoder.sv
tb/tb_ascii_line_command_decoder.sv
